>>> src/dbrp_pkg.sv
`default_nettype none

package dbrp_pkg;

    // ring geometry (slot of a position is its low bits, so SLOTS is a power of two)
    localparam int SLOTS  = 64;
    localparam int SLOT_W = $clog2(SLOTS);

    // field widths
    localparam int POS_W = 48;
    localparam int IDX_W = 31;
    localparam int PAY_W = 32;
    localparam int CNT_W = 7;
    localparam int OCC_W = $clog2(SLOTS + 1);

    // operation codes
    typedef enum logic [1:0] {
        FUNC_PUT   = 2'd0,
        FUNC_FIND  = 2'd1,
        FUNC_DRAIN = 2'd2,
        FUNC_EVICT = 2'd3
    } t_func;

    // result status codes
    typedef enum logic [1:0] {
        STAT_OK   = 2'd0,
        STAT_FULL = 2'd1,
        STAT_MISS = 2'd2,
        STAT_SAT  = 2'd3
    } t_status;

    // sequencer states
    typedef enum logic [1:0] {
        S_IDLE  = 2'd0,
        S_EXEC  = 2'd1,
        S_FIND  = 2'd2,
        S_DRAIN = 2'd3
    } t_state;

    // one ring entry as stored in the slot memory
    typedef struct packed {
        logic [IDX_W-1:0] idx;
        logic [PAY_W-1:0] pay;
    } t_entry;

endpackage

`default_nettype wire

>>> src/dbrp_ram.sv
`default_nettype none

module dbrp_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    // one write port, one registered read port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule

`default_nettype wire

>>> src/dirty_block_ring_pool_core.sv
`default_nettype none
// channel   | direction | transfer when     | fields
// ----------+-----------+-------------------+---------------------------------------------
// command   | in        | start & !busy     | func, block_index, block_id, payload_handle,
//           |           |                   | count
// result    | out       | o_valid (1 cycle) | status, out_block_id, out_block_index,
//           |           |                   | out_payload, occupancy, last
//
// put and evict are latched, then executed; find is latched, read, then compared.
// a drain read gives one entry a cycle from the slot memory, whose registered read port
// is pipelined one address ahead; an empty drain gives a single miss result.
// busy is high from the cycle after a command transfer until its last result is out.
// synchronous active-low reset clears head, tail and occupancy; the slot memory is not
// cleared. results cannot be held off: each stands on the ports for one cycle only.

module dirty_block_ring_pool_core (
    input  wire logic                       i_clk,
    input  wire logic                       i_rst_n,
    input  wire logic                       start,
    output logic                            busy,
    input  wire logic [1:0]                 i_func,
    input  wire logic [dbrp_pkg::IDX_W-1:0] i_block_index,
    input  wire logic [dbrp_pkg::POS_W-1:0] i_block_id,
    input  wire logic [dbrp_pkg::PAY_W-1:0] i_payload_handle,
    input  wire logic [dbrp_pkg::CNT_W-1:0] i_count,
    output logic                            o_valid,
    output logic [1:0]                      o_status,
    output logic [dbrp_pkg::POS_W-1:0]      o_out_block_id,
    output logic [dbrp_pkg::IDX_W-1:0]      o_out_block_index,
    output logic [dbrp_pkg::PAY_W-1:0]      o_out_payload,
    output logic [dbrp_pkg::OCC_W-1:0]      o_occupancy,
    output logic                            o_last
);

    localparam int POS_W  = dbrp_pkg::POS_W;
    localparam int IDX_W  = dbrp_pkg::IDX_W;
    localparam int PAY_W  = dbrp_pkg::PAY_W;
    localparam int CNT_W  = dbrp_pkg::CNT_W;
    localparam int OCC_W  = dbrp_pkg::OCC_W;
    localparam int SLOT_W = dbrp_pkg::SLOT_W;

    // control state
    dbrp_pkg::t_state  r_state, n_state;
    logic [POS_W-1:0]  r_head, n_head;
    logic [POS_W-1:0]  r_tail, n_tail;
    logic [OCC_W-1:0]  r_occ, n_occ;
    logic [CNT_W-1:0]  r_left, n_left;
    logic              r_o_valid, n_o_valid;

    // latched command and walk position
    dbrp_pkg::t_func   r_func, n_func;
    logic [IDX_W-1:0]  r_bidx, n_bidx;
    logic [POS_W-1:0]  r_bid, n_bid;
    logic [PAY_W-1:0]  r_pay, n_pay;
    logic [CNT_W-1:0]  r_cnt, n_cnt;
    logic [POS_W-1:0]  r_pos, n_pos;

    // result registers
    dbrp_pkg::t_status r_o_status, n_o_status;
    logic [POS_W-1:0]  r_o_id, n_o_id;
    logic [IDX_W-1:0]  r_o_idx, n_o_idx;
    logic [PAY_W-1:0]  r_o_pay, n_o_pay;
    logic [OCC_W-1:0]  r_o_occ, n_o_occ;
    logic              r_o_last, n_o_last;

    // slot memory port
    logic              ram_we;
    logic [SLOT_W-1:0] ram_waddr;
    logic [SLOT_W-1:0] ram_raddr;
    dbrp_pkg::t_entry  ram_wdata;
    dbrp_pkg::t_entry  ram_rdata;

    // shared position adder
    logic [POS_W-1:0]  add_a;
    logic [POS_W-1:0]  add_b;
    logic [POS_W-1:0]  add_sum;

    // misc
    logic [CNT_W-1:0]  take;
    logic              full;
    logic [SLOT_W-1:0] slot_diff;
    logic              in_window;
    logic              hit;

    dbrp_ram #(
        .WIDTH ($bits(dbrp_pkg::t_entry)),
        .DEPTH (dbrp_pkg::SLOTS)
    ) u_slots (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    // entries to drain or evict, clipped at occupancy
    always_comb begin
        take = (r_cnt < CNT_W'(r_occ)) ? r_cnt : CNT_W'(r_occ);
        full = (r_occ == OCC_W'(dbrp_pkg::SLOTS));
    end

    // window test for the requested slot
    always_comb begin
        slot_diff = r_bid[SLOT_W-1:0] - r_head[SLOT_W-1:0];
        in_window = full || (OCC_W'(slot_diff) < r_occ);
        hit       = in_window && (ram_rdata.idx == r_bidx);
    end

    // operand select for the shared adder
    always_comb begin
        add_a = r_pos;
        add_b = POS_W'(1);
        if (r_state == dbrp_pkg::S_EXEC) begin
            if (r_func == dbrp_pkg::FUNC_PUT) begin
                add_a = r_tail;
            end else begin
                add_a = r_head;
                add_b = POS_W'(take);
            end
        end
        add_sum = add_a + add_b;
    end

    // sequencer next state and outputs
    always_comb begin
        n_state    = r_state;
        n_head     = r_head;
        n_tail     = r_tail;
        n_occ      = r_occ;
        n_left     = r_left;
        n_func     = r_func;
        n_bidx     = r_bidx;
        n_bid      = r_bid;
        n_pay      = r_pay;
        n_cnt      = r_cnt;
        n_pos      = r_pos;
        n_o_valid  = 1'b0;
        n_o_status = dbrp_pkg::STAT_OK;
        n_o_id     = '0;
        n_o_idx    = '0;
        n_o_pay    = '0;
        n_o_occ    = r_occ;
        n_o_last   = 1'b1;
        ram_we     = 1'b0;
        ram_waddr  = r_tail[SLOT_W-1:0];
        ram_wdata  = '{idx: r_bidx, pay: r_pay};
        ram_raddr  = add_sum[SLOT_W-1:0];

        unique case (r_state)
            dbrp_pkg::S_IDLE: begin
                // command transfer
                if (start) begin
                    n_func  = dbrp_pkg::t_func'(i_func);
                    n_bidx  = i_block_index;
                    n_bid   = i_block_id;
                    n_pay   = i_payload_handle;
                    n_cnt   = i_count;
                    n_state = dbrp_pkg::S_EXEC;
                end
            end
            dbrp_pkg::S_EXEC: begin
                unique case (r_func)
                    dbrp_pkg::FUNC_PUT: begin
                        n_o_valid = 1'b1;
                        n_state   = dbrp_pkg::S_IDLE;
                        if (full) begin
                            n_o_status = dbrp_pkg::STAT_FULL;
                        end else begin
                            ram_we  = 1'b1;
                            n_o_id  = r_tail;
                            n_tail  = add_sum;
                            n_occ   = r_occ + OCC_W'(1);
                            n_o_occ = r_occ + OCC_W'(1);
                        end
                    end
                    dbrp_pkg::FUNC_FIND: begin
                        ram_raddr = r_bid[SLOT_W-1:0];
                        n_state   = dbrp_pkg::S_FIND;
                    end
                    dbrp_pkg::FUNC_DRAIN: begin
                        ram_raddr = r_head[SLOT_W-1:0];
                        n_pos     = r_head;
                        n_left    = take;
                        if (take == '0) begin
                            n_o_valid  = 1'b1;
                            n_o_status = dbrp_pkg::STAT_MISS;
                            n_state    = dbrp_pkg::S_IDLE;
                        end else begin
                            n_state = dbrp_pkg::S_DRAIN;
                        end
                    end
                    dbrp_pkg::FUNC_EVICT: begin
                        n_head     = add_sum;
                        n_occ      = r_occ - OCC_W'(take);
                        n_o_occ    = r_occ - OCC_W'(take);
                        n_o_status = (r_cnt > CNT_W'(r_occ)) ? dbrp_pkg::STAT_SAT
                                                             : dbrp_pkg::STAT_OK;
                        n_o_valid  = 1'b1;
                        n_state    = dbrp_pkg::S_IDLE;
                    end
                    default: begin
                        n_state = dbrp_pkg::S_IDLE;
                    end
                endcase
            end
            dbrp_pkg::S_FIND: begin
                // memory data for the requested slot is here
                n_o_valid = 1'b1;
                n_state   = dbrp_pkg::S_IDLE;
                if (hit) begin
                    n_o_id  = r_bid;
                    n_o_idx = ram_rdata.idx;
                    n_o_pay = ram_rdata.pay;
                end else begin
                    n_o_status = dbrp_pkg::STAT_MISS;
                end
            end
            dbrp_pkg::S_DRAIN: begin
                // emit entry at r_pos, read one ahead
                n_o_valid = 1'b1;
                n_o_id    = r_pos;
                n_o_idx   = ram_rdata.idx;
                n_o_pay   = ram_rdata.pay;
                n_o_last  = (r_left == CNT_W'(1));
                n_pos     = add_sum;
                n_left    = r_left - CNT_W'(1);
                if (r_left == CNT_W'(1)) begin
                    n_state = dbrp_pkg::S_IDLE;
                end
            end
            default: begin
                n_state = dbrp_pkg::S_IDLE;
            end
        endcase
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= dbrp_pkg::S_IDLE;
            r_head    <= '0;
            r_tail    <= '0;
            r_occ     <= '0;
            r_left    <= '0;
            r_o_valid <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_head    <= n_head;
            r_tail    <= n_tail;
            r_occ     <= n_occ;
            r_left    <= n_left;
            r_o_valid <= n_o_valid;
        end
    end

    // command and result registers
    always_ff @(posedge i_clk) begin
        r_func     <= n_func;
        r_bidx     <= n_bidx;
        r_bid      <= n_bid;
        r_pay      <= n_pay;
        r_cnt      <= n_cnt;
        r_pos      <= n_pos;
        r_o_status <= n_o_status;
        r_o_id     <= n_o_id;
        r_o_idx    <= n_o_idx;
        r_o_pay    <= n_o_pay;
        r_o_occ    <= n_o_occ;
        r_o_last   <= n_o_last;
    end

    // ports
    assign busy              = (r_state != dbrp_pkg::S_IDLE);
    assign o_valid           = r_o_valid;
    assign o_status          = r_o_status;
    assign o_out_block_id    = r_o_id;
    assign o_out_block_index = r_o_idx;
    assign o_out_payload     = r_o_pay;
    assign o_occupancy       = r_o_occ;
    assign o_last            = r_o_last;

endmodule

`default_nettype wire
